FILE: rtl/register_access_pec_framer_macros.svh
// Assertion macros for the register access PEC framer.
`ifndef REGISTER_ACCESS_PEC_FRAMER_MACROS_SVH
`define REGISTER_ACCESS_PEC_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define RAPF_ASSERT_SAME(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define RAPF_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define RAPF_ASSERT_SAME(lbl, clk, rst_n, a, b)
`define RAPF_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/rapf_pkg.sv
// Types, constants and the CRC-8 byte step shared by the PEC framer.
`timescale 1ns / 1ps
package rapf_pkg;

	localparam logic [7:0] PEC_POLY   = 8'h07;
	localparam logic [7:0] PEC_INIT   = 8'h00;
	localparam logic [6:0] ADDR_RESET = 7'd11;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [1:0] WR_LAST_IDX = 2'd3;
	localparam logic [1:0] RD_LAST_IDX = 2'd0;

	typedef struct packed {
		logic        kind;
		logic [7:0]  register_index;
		logic [15:0] data_word;
		logic [7:0]  received_check;
	} pec_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] read_value;
		logic        check_ok;
		logic        last;
	} pec_out_t;

	// first stage to serializer
	typedef struct packed {
		logic        valid;
		pec_in_t     item;
		logic [7:0]  crc_reg;
	} pec_xfer_t;

	// MSB-first CRC-8 over one byte
	function automatic logic [7:0] pec_byte(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ PEC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

FILE: rtl/rapf_front.sv
// Input register stage: captures a word and folds the register byte into the CRC.
`timescale 1ns / 1ps
module rapf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rapf_pkg::pec_in_t   in_data,
	input  logic [7:0]          crc_wa,
	input  logic                take,
	output rapf_pkg::pec_xfer_t xfer
);

	logic                valid_s1;
	rapf_pkg::pec_in_t   item_s1;
	logic [7:0]          crc_s1;
	logic                in_acc;

	assign in_stall = valid_s1 && !take;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
			crc_s1  <= rapf_pkg::pec_byte(crc_wa, in_data.register_index);
		end
	end

	assign xfer.valid   = valid_s1;
	assign xfer.item    = item_s1;
	assign xfer.crc_reg = crc_s1;

endmodule

FILE: rtl/rapf_serial.sv
// Result stage: finishes the CRC and sends the frame one byte per cycle while out_stall is low.
`timescale 1ns / 1ps
`include "register_access_pec_framer_macros.svh"
module rapf_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  rapf_pkg::pec_xfer_t xfer,
	input  logic [7:0]          ra_byte,
	output logic                take,
	output logic                out_valid,
	input  logic                out_stall,
	output rapf_pkg::pec_out_t  out_data
);

	logic        valid_s2;
	logic [7:0]  bytes_s2 [4];
	logic [1:0]  idx_s2;
	logic [1:0]  last_idx_s2;
	logic        kind_s2;
	logic [15:0] word_s2;
	logic        ok_s2;

	logic        out_acc;
	logic        is_last;
	logic        done;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic [7:0]  crc_wr;
	logic [7:0]  crc_rd;

	assign lo = xfer.item.data_word[7:0];
	assign hi = xfer.item.data_word[15:8];

	assign crc_wr = rapf_pkg::pec_byte(rapf_pkg::pec_byte(xfer.crc_reg, lo), hi);
	assign crc_rd = rapf_pkg::pec_byte(rapf_pkg::pec_byte(
		rapf_pkg::pec_byte(xfer.crc_reg, ra_byte), lo), hi);

	assign is_last = (idx_s2 == last_idx_s2);
	assign out_acc = valid_s2 && !out_stall;
	assign done    = out_acc && is_last;
	assign take    = xfer.valid && (!valid_s2 || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (take) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 2'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (out_acc) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s2 <= xfer.item.kind;
			word_s2 <= xfer.item.data_word;
			if (xfer.item.kind == rapf_pkg::KIND_READ) begin
				bytes_s2[0] <= crc_rd;
				bytes_s2[1] <= 8'h00;
				bytes_s2[2] <= 8'h00;
				bytes_s2[3] <= 8'h00;
				last_idx_s2 <= rapf_pkg::RD_LAST_IDX;
				ok_s2       <= (crc_rd == xfer.item.received_check);
			end else begin
				bytes_s2[0] <= xfer.item.register_index;
				bytes_s2[1] <= lo;
				bytes_s2[2] <= hi;
				bytes_s2[3] <= crc_wr;
				last_idx_s2 <= rapf_pkg::WR_LAST_IDX;
				ok_s2       <= 1'b1;
			end
		end
	end

	assign out_valid           = valid_s2;
	assign out_data.out_byte   = bytes_s2[idx_s2];
	assign out_data.read_value = (kind_s2 == rapf_pkg::KIND_READ) ? word_s2 : 16'h0000;
	assign out_data.check_ok   = (kind_s2 == rapf_pkg::KIND_READ) ? ok_s2 : 1'b1;
	assign out_data.last       = is_last;

	// a frame keeps going until its last word is taken
	`RAPF_ASSERT_NEXT(a_frame_cont, clk, arst_n, out_acc && !is_last, valid_s2)
	`RAPF_ASSERT_SAME(a_idx_range, clk, arst_n, valid_s2, idx_s2 <= last_idx_s2)
	`RAPF_ASSERT_SAME(a_read_single, clk, arst_n, valid_s2 && kind_s2 == rapf_pkg::KIND_READ,
		out_data.last && idx_s2 == rapf_pkg::RD_LAST_IDX)

endmodule

FILE: rtl/register_access_pec_framer.sv
// Top level: address register, input stage and frame serializer.
// An input word is registered in the input stage and then loaded into the serializer.
// Throughput: a write emits four words and a read one check word, one word per cycle while
// out_stall is low; the next item is loaded while the last word goes.
// Reset: asynchronous, active low; clears pipeline valids and sets the address to 11.
`timescale 1ns / 1ps
module register_access_pec_framer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rapf_pkg::pec_in_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output rapf_pkg::pec_out_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);

	logic [6:0]          addr_q;
	logic [7:0]          crc_wa_q;
	logic                take;
	rapf_pkg::pec_xfer_t xfer;

	assign cfg_ready = 1'b1;

	// CRC of the write address byte is fixed between config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= rapf_pkg::ADDR_RESET;
			crc_wa_q <= rapf_pkg::pec_byte(rapf_pkg::PEC_INIT, {rapf_pkg::ADDR_RESET, 1'b0});
		end else if (cfg_valid && cfg_ready) begin
			addr_q   <= cfg_data;
			crc_wa_q <= rapf_pkg::pec_byte(rapf_pkg::PEC_INIT, {cfg_data, 1'b0});
		end
	end

	rapf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.crc_wa   (crc_wa_q),
		.take     (take),
		.xfer     (xfer)
	);

	rapf_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.xfer      (xfer),
		.ra_byte   ({addr_q, 1'b1}),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
